// File: rtl/svdls_pkg.sv
`default_nettype none
package svdls_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 16;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);

  typedef enum logic [2:0] {
    OP_LOAD_U = 3'd0,
    OP_LOAD_V = 3'd1,
    OP_LOAD_W = 3'd2,
    OP_LOAD_B = 3'd3,
    OP_SOLVE  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_COLS  = 2'd1,
    REG_RATIO = 2'd2
  } reg_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         param_index;
    logic signed [31:0] param_value;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DOT_RD,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_COEF,
    ST_COEF_ACC,
    ST_V_RD,
    ST_V_MUL,
    ST_V_ACC,
    ST_OUT_RD,
    ST_OUT
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic write_load;   // store the accepted load item
    logic div_start;    // start inverse of W[i]
    logic rd_dot;       // read U[j][i], b[j]
    logic mul_dot;      // register product operands result
    logic acc_dot;      // dot += product
    logic clr_dot;
    logic mul_coef;     // coef = dot * inv
    logic rd_v;         // read V[j][i], acc[j]
    logic mul_v;
    logic acc_v;        // acc[j] += product
    logic clr_acc;      // start acc[j] from zero instead of its old value
    logic rd_out;       // read acc[j]
    logic [RowW-1:0] j;
    logic [ColW-1:0] i;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  // (a*b)>>16 truncated toward zero, saturated to 64 bits; magnitudes given
  function automatic logic signed [63:0] sat_scale(input logic neg,
                                                   input logic [95:0] mag);
    logic [79:0] sh;
    logic [63:0] lim;
    logic [63:0] r;
    sh  = mag[95:16];
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (sh > {16'd0, lim}) r = lim;
    else r = sh[63:0];
    return neg ? -r : r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/svdls_div.sv
`default_nettype none
// Restoring divider: 2^32 / w, one quotient bit per cycle, 33 bits.
module svdls_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] w_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);
  import svdls_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        neg_q, neg_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic        done_q, done_d;
  logic [33:0] trial;
  logic [33:0] qmag;
  logic signed [34:0] qs;

  // dividend 2^32: bit 32 set, others zero
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    trial  = {rem_q, (cnt_q == 6'd32)};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      neg_d  = w_i[31];
      den_d  = w_i[31] ? 32'(-w_i) : w_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      if (trial >= {2'b00, den_q}) begin
        rem_d = 33'(trial - {2'b00, den_q});
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = trial[32:0];
        quo_d = {quo_q[31:0], 1'b0};
      end
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign qmag   = {1'b0, quo_q};
  assign qs     = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign done_o = done_q;
  assign quot_o = sat32(64'(qs));
endmodule
`default_nettype wire

// File: rtl/svdls_ctrl.sv
`default_nettype none
module svdls_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire svdls_pkg::in_item_t   in_data_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [3:0]                 out_index_o,
  output logic                       out_last_o,
  input  wire logic [6:0]            rows_i,
  input  wire logic [4:0]            cols_i,
  input  wire svdls_pkg::stat_t      stat_i,
  output svdls_pkg::cmd_t            cmd_o
);
  import svdls_pkg::*;

  state_e state_q, state_d;
  logic [RowW:0]   m_q, m_d;
  logic [ColW:0]   n_q, n_d;
  logic [RowW-1:0] j_q, j_d;
  logic [ColW-1:0] i_q, i_d;
  logic            ov_q, ov_d;
  logic            first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      m_q <= '0; n_q <= '0; j_q <= '0; i_q <= '0;
      ov_q <= 1'b0; first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      m_q <= m_d; n_q <= n_d; j_q <= j_d; i_q <= i_d;
      ov_q <= ov_d; first_q <= first_d;
    end
  end

  always_comb begin
    state_d = state_q;
    m_d = m_q; n_d = n_q; j_d = j_q; i_d = i_q;
    ov_d = ov_q; first_d = first_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.operation == OP_SOLVE) begin
            m_d = (rows_i == 7'd0) ? 7'd1 : ((rows_i > 7'(MaxRows)) ? 7'(MaxRows) : rows_i);
            n_d = (cols_i == 5'd0) ? 5'd1 : ((cols_i > 5'(MaxCols)) ? 5'(MaxCols) : cols_i);
            i_d = '0;
            first_d = 1'b1;
            state_d = ST_DIV;
            cmd_o.div_start = 1'b1;
          end else begin
            cmd_o.write_load = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd_o.clr_dot = 1'b1;
        j_d = '0;
        if (stat_i.div_done) state_d = ST_DOT_RD;
      end
      ST_DOT_RD: begin
        cmd_o.rd_dot = 1'b1;
        state_d = ST_DOT_MUL;
      end
      ST_DOT_MUL: begin
        cmd_o.mul_dot = 1'b1;
        state_d = ST_DOT_ACC;
      end
      ST_DOT_ACC: begin
        cmd_o.acc_dot = 1'b1;
        if (7'(j_q) == m_q - 7'd1) begin
          state_d = ST_COEF;
        end else begin
          j_d = j_q + 1'b1;
          state_d = ST_DOT_RD;
        end
      end
      ST_COEF: begin
        cmd_o.mul_coef = 1'b1;
        state_d = ST_COEF_ACC;
      end
      ST_COEF_ACC: begin
        j_d = '0;
        state_d = ST_V_RD;
      end
      ST_V_RD: begin
        cmd_o.rd_v = 1'b1;
        state_d = ST_V_MUL;
      end
      ST_V_MUL: begin
        cmd_o.mul_v = 1'b1;
        state_d = ST_V_ACC;
      end
      ST_V_ACC: begin
        cmd_o.acc_v = 1'b1;
        cmd_o.clr_acc = first_q;
        if (5'(j_q) == n_q - 5'd1) begin
          first_d = 1'b0;
          if (5'(i_q) == n_q - 5'd1) begin
            j_d = '0;
            state_d = ST_OUT_RD;
          end else begin
            i_d = i_q + 1'b1;
            cmd_o.div_start = 1'b1;
            state_d = ST_DIV;
          end
        end else begin
          j_d = j_q + 1'b1;
          state_d = ST_V_RD;
        end
      end
      ST_OUT_RD: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.rd_out = 1'b1;
          ov_d = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (5'(j_q) == n_q - 5'd1) begin
            state_d = ST_IDLE;
          end else begin
            j_d = j_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.j = j_q;
    // next column, so a divider start reads the singular value it inverts
    cmd_o.i = i_d;
  end

  assign out_valid_o = ov_q;
  assign out_index_o = 4'(j_q);
  assign out_last_o  = (5'(j_q) == n_q - 5'd1);

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == ST_OUT) else $error("result outside output state");
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> (n_q >= 5'd1 && m_q >= 7'd1)) else $error("bad size");
endmodule
`default_nettype wire

// File: rtl/svdls_dp.sv
`default_nettype none
module svdls_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire svdls_pkg::in_item_t in_data_i,
  input  wire logic [5:0]          ratio_i,
  input  wire svdls_pkg::cmd_t     cmd_i,
  output svdls_pkg::stat_t         stat_o,
  output logic signed [31:0]       out_value_o
);
  import svdls_pkg::*;

  logic [31:0] u_mem [MaxRows*MaxCols];
  logic [31:0] v_mem [MaxCols*MaxCols];
  logic [31:0] w_mem [MaxCols];
  logic [31:0] b_mem [MaxRows];
  logic signed [63:0] acc_mem [MaxCols];

  logic signed [31:0] ra_q, rb_q;
  logic signed [63:0] racc_q;
  logic               pneg_q;
  logic [95:0]        pmag_q;
  logic signed [63:0] dot_q, coef_q;
  logic signed [31:0] inv_q, out_q;
  logic               keep_q;
  logic               div_done;
  logic signed [31:0] quot;
  logic signed [31:0] wi, w0;
  logic               keep;
  logic signed [63:0] wsh;
  logic signed [63:0] opa;
  logic signed [31:0] opb;
  logic [63:0]        amag;
  logic [31:0]        bmag;

  // loads
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_load) begin
      case (in_data_i.operation)
        OP_LOAD_U: u_mem[{in_data_i.row, in_data_i.col}] <= in_data_i.value;
        OP_LOAD_V: if (in_data_i.row < 6'(MaxCols))
          v_mem[{in_data_i.row[ColW-1:0], in_data_i.col}] <= in_data_i.value;
        OP_LOAD_W: if (in_data_i.row < 6'(MaxCols))
          w_mem[in_data_i.row[ColW-1:0]] <= in_data_i.value;
        OP_LOAD_B: b_mem[in_data_i.row] <= in_data_i.value;
        default: ;
      endcase
    end
  end

  // inverse with cutoff
  assign wi  = w_mem[cmd_i.i];
  assign w0  = w_mem[0];
  assign wsh = 64'(wi) <<< ratio_i;
  always_comb begin
    if (wi == 32'sd0) keep = 1'b0;
    else if (ratio_i >= 6'd32) keep = !wi[31];
    else keep = wsh > 64'(w0);
  end

  svdls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .w_i     (wi),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) keep_q <= keep;
    if (div_done) inv_q <= keep_q ? quot : 32'sd0;
  end

  assign stat_o.div_done = div_done;

  // operand reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_dot) begin
      ra_q <= u_mem[{cmd_i.j, cmd_i.i}];
      rb_q <= b_mem[cmd_i.j];
    end else if (cmd_i.rd_v) begin
      rb_q   <= v_mem[{cmd_i.j[ColW-1:0], cmd_i.i}];
      racc_q <= acc_mem[cmd_i.j[ColW-1:0]];
    end
  end

  // shared multiplier (split 32x32 partials in one stage, operand b <= 32 bits)
  always_comb begin
    if (cmd_i.mul_dot) begin
      opa = 64'(ra_q);
      opb = rb_q;
    end else if (cmd_i.mul_coef) begin
      opa = dot_q;
      opb = inv_q;
    end else begin
      opa = coef_q;
      opb = rb_q;
    end
    amag = abs64(opa);
    bmag = opb[31] ? 32'(-opb) : opb;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_dot || cmd_i.mul_coef || cmd_i.mul_v) begin
      pneg_q <= (opa[63] != opb[31]) && opa != 0 && opb != 0;
      pmag_q <= {64'd0, amag[31:0]} * {64'd0, bmag}
              + ({64'd0, amag[63:32]} * {64'd0, bmag} << 32);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_dot) dot_q <= '0;
    else if (cmd_i.acc_dot) dot_q <= sat_add(dot_q, sat_scale(pneg_q, pmag_q));
  end

  // coef_q loads the scaled product in ST_COEF_ACC, via coef_ld_q registered from mul_coef
  logic coef_ld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) coef_ld_q <= 1'b0;
    else coef_ld_q <= cmd_i.mul_coef;
  end
  always_ff @(posedge clk_i) begin
    if (coef_ld_q) coef_q <= sat_scale(pneg_q, pmag_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_v)
      acc_mem[cmd_i.j[ColW-1:0]] <= sat_add(cmd_i.clr_acc ? 64'sd0 : racc_q,
                                            sat_scale(pneg_q, pmag_q));
    if (cmd_i.rd_out) out_q <= sat32(acc_mem[cmd_i.j[ColW-1:0]]);
  end

  assign out_value_o = out_q;
endmodule
`default_nettype wire

// File: rtl/svd_least_squares_solve_unit.sv
`default_nettype none
// Least-squares solve from a loaded SVD, signed Q16.16.
// Load items: one transfer per cycle while idle, no result.
// Solve: per singular value a bit-serial inverse, the U.b dot product over m rows,
// the coefficient and the V update over n rows; then n results, each read and
// then presented until taken; input held off.
// Reset: control, config reset at once (m=64, n=16, shift=42); datapath undefined.
module svd_least_squares_solve_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire svdls_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output svdls_pkg::out_item_t      out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);
  import svdls_pkg::*;

  logic [6:0] rows_q;
  logic [4:0] cols_q;
  logic [5:0] ratio_q;
  cmd_t  cmd;
  stat_t stat;
  logic [3:0] oidx;
  logic       olast;
  logic signed [31:0] oval;

  // configuration always taken
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 7'd64;
      cols_q  <= 5'd16;
      ratio_q <= 6'd42;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROWS:  rows_q  <= cfg_data_i[6:0];
        REG_COLS:  cols_q  <= cfg_data_i[4:0];
        REG_RATIO: ratio_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  svdls_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .out_index_o (oidx),
    .out_last_o  (olast),
    .rows_i      (rows_q),
    .cols_i      (cols_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  svdls_dp u_dp (
    .clk_i, .rst_ni, .in_data_i,
    .ratio_i     (ratio_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_value_o (oval)
  );

  assign out_data_o.param_index = oidx;
  assign out_data_o.param_value = oval;
  assign out_data_o.last        = olast;
endmodule
`default_nettype wire
